// ===== rtl/core/i2c_reg_pkg.sv =====
`default_nettype none

package i2c_reg_pkg;

    // Item kinds
    localparam logic CMD_START = 1'b0;
    localparam logic CMD_EVENT = 1'b1;

    // Transaction direction
    localparam logic DIR_READ  = 1'b0;
    localparam logic DIR_WRITE = 1'b1;

    // Status codes
    localparam logic [1:0] ST_AVAIL = 2'd0;
    localparam logic [1:0] ST_BUSY  = 2'd1;
    localparam logic [1:0] ST_ERR   = 2'd2;

    // Sequence positions, counted from one after the start
    localparam logic [2:0] POS_IDLE = 3'd0;
    localparam logic [2:0] POS_REG  = 3'd1;
    localparam logic [2:0] POS_SEC  = 3'd2;
    localparam logic [2:0] POS_RXM  = 3'd3;
    localparam logic [2:0] POS_DATA = 3'd4;

    localparam int SLAVE_ADDR_W = 7;

    typedef struct packed {
        logic       cmd;
        logic       direction;
        logic [7:0] reg_addr;
        logic [7:0] write_data;
        logic [7:0] read_count;
        logic       bus_busy;
        logic       arb_lost;
        logic [7:0] rx_byte;
    } t_in_word;

    typedef struct packed {
        logic       accepted;
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       send_start;
        logic       repeated_start;
        logic       rx_mode;
        logic       send_nak;
        logic       rx_valid;
        logic [7:0] rx_data;
        logic       stop;
        logic       done_res;
        logic [1:0] status;
    } t_out_word;

endpackage

`default_nettype wire

// ===== rtl/core/i2c_master_register_transaction.sv =====
`default_nettype none

// Channel   Direction  Handshake                  Payload
// in        to block   i_in_valid / o_in_ready    i_in_word  (i2c_reg_pkg::t_in_word)
// out       from block o_out_valid / i_out_ready  o_out_word (i2c_reg_pkg::t_out_word)
// cfg       to block   i_cfg_wr_en, no wait       i_cfg_wr_data (seven-bit slave address)
//
// Each accepted word is held in an input register, then the sequencer step runs on it
// and its result lands in the output register, so a word passes through the input
// register and then the output register, and one word may enter per cycle while the output is not stalled.
// Reset is synchronous and active low; it clears the handshake flags, the sequencer
// state and the slave address. When the output register is stalled the input register
// holds its word and the input side keeps accepting only while that register is free.

module i2c_master_register_transaction (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   i_in_valid,
    output logic                                        o_in_ready,
    input  wire i2c_reg_pkg::t_in_word                  i_in_word,
    output logic                                        o_out_valid,
    input  wire logic                                   i_out_ready,
    output i2c_reg_pkg::t_out_word                      o_out_word,
    input  wire logic                                   i_cfg_wr_en,
    input  wire logic [i2c_reg_pkg::SLAVE_ADDR_W-1:0]  i_cfg_wr_data
);
    import i2c_reg_pkg::*;

    // Input stage
    logic      r_in_valid;
    t_in_word  r_in;

    // Output stage
    logic      r_out_valid;
    t_out_word r_out;

    // Sequencer state and configuration
    logic [SLAVE_ADDR_W-1:0] r_slave_addr;
    logic [1:0]              r_status, n_status;
    logic [2:0]              r_pos, n_pos;
    logic                    r_dir, n_dir;
    logic [7:0]              r_reg, n_reg;
    logic [7:0]              r_data, n_data;
    logic [7:0]              r_remaining, n_remaining;

    t_out_word  n_out;
    logic       adv;
    logic [7:0] wr_addr;
    logic [7:0] rd_addr;
    logic [7:0] rem_dec;

    // The step advances when the input register holds a word and the output register is empty or being emptied.
    assign adv         = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || adv;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    assign wr_addr = {r_slave_addr, 1'b0};
    assign rd_addr = {r_slave_addr, 1'b1};
    assign rem_dec = (r_remaining != 8'd0) ? r_remaining - 8'd1 : 8'd0;

    // One step of the transaction sequence for the word in the input register.
    always_comb begin
        n_status    = r_status;
        n_pos       = r_pos;
        n_dir       = r_dir;
        n_reg       = r_reg;
        n_data      = r_data;
        n_remaining = r_remaining;
        n_out       = '0;

        if (r_in.cmd == CMD_START) begin
            // A start is taken only when no transaction runs and the bus is free.
            if (r_status != ST_BUSY && !r_in.bus_busy) begin
                n_dir       = r_in.direction;
                n_reg       = r_in.reg_addr;
                n_data      = r_in.write_data;
                n_remaining = (r_in.read_count == 8'd0) ? 8'd1 : r_in.read_count;
                if (r_in.arb_lost) begin
                    n_out.stop = 1'b1;
                    n_status   = ST_ERR;
                    n_pos      = POS_IDLE;
                end else begin
                    n_out.accepted   = 1'b1;
                    n_out.send_start = 1'b1;
                    n_out.tx_valid   = 1'b1;
                    n_out.tx_byte    = wr_addr;
                    n_status         = ST_BUSY;
                    n_pos            = POS_REG;
                end
            end
        end else if (r_status == ST_BUSY) begin
            priority if (r_in.arb_lost) begin
                n_out.stop = 1'b1;
                n_status   = ST_ERR;
                n_pos      = POS_IDLE;
            end else if (r_pos <= POS_REG) begin
                // Register address goes out first for both directions.
                n_out.tx_valid = 1'b1;
                n_out.tx_byte  = r_reg;
                n_pos          = POS_SEC;
            end else if (r_dir == DIR_WRITE) begin
                if (r_pos == POS_SEC) begin
                    n_out.tx_valid = 1'b1;
                    n_out.tx_byte  = r_data;
                    n_pos          = POS_RXM;
                end else begin
                    n_out.stop     = 1'b1;
                    n_out.done_res = 1'b1;
                    n_status       = ST_AVAIL;
                    n_pos          = POS_IDLE;
                end
            end else begin
                priority if (r_pos == POS_SEC) begin
                    n_out.repeated_start = 1'b1;
                    n_out.tx_valid       = 1'b1;
                    n_out.tx_byte        = rd_addr;
                    n_pos                = POS_RXM;
                end else if (r_pos == POS_RXM) begin
                    // Dummy read; a single-byte read is NAKed straight away.
                    n_out.rx_mode  = 1'b1;
                    n_out.send_nak = (r_remaining <= 8'd1);
                    n_pos          = POS_DATA;
                end else if (r_pos == POS_DATA) begin
                    n_out.rx_valid = 1'b1;
                    n_out.rx_data  = r_in.rx_byte;
                    n_remaining    = rem_dec;
                    if (rem_dec == 8'd0) begin
                        n_out.stop     = 1'b1;
                        n_out.done_res = 1'b1;
                        n_status       = ST_AVAIL;
                        n_pos          = POS_IDLE;
                    end else if (rem_dec == 8'd1) begin
                        n_out.send_nak = 1'b1;
                    end
                end else begin
                    n_out.stop     = 1'b1;
                    n_out.done_res = 1'b1;
                    n_status       = ST_AVAIL;
                    n_pos          = POS_IDLE;
                end
            end
        end

        n_out.status = n_status;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_slave_addr <= '0;
            r_status     <= ST_AVAIL;
            r_pos        <= POS_IDLE;
            r_dir        <= 1'b0;
            r_reg        <= '0;
            r_data       <= '0;
            r_remaining  <= '0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (adv) begin
                r_out_valid <= 1'b1;
                r_status    <= n_status;
                r_pos       <= n_pos;
                r_dir       <= n_dir;
                r_reg       <= n_reg;
                r_data      <= n_data;
                r_remaining <= n_remaining;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_wr_en) begin
                r_slave_addr <= i_cfg_wr_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_word;
        end
        if (adv) begin
            r_out <= n_out;
        end
    end

    // A held result always reports the status that the sequencer now holds.
    a_status_tracks : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_word.status == r_status))
        else $error("result status differs from sequencer status");

    // A successful finish always releases the bus.
    a_done_stop : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_word.done_res) |-> o_out_word.stop)
        else $error("done without stop");

    // An accepted start sends the write address with a start and leaves the block busy.
    a_accept_start : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_word.accepted) |->
            (o_out_word.send_start && o_out_word.tx_valid && r_status == ST_BUSY
             && o_out_word.tx_byte == wr_addr))
        else $error("accepted start malformed");

    // Read bytes are only delivered during a read transaction.
    a_rx_read_only : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_word.rx_valid) |-> (r_dir == DIR_READ))
        else $error("read byte delivered in a write transaction");

    // The stalled input word waits while the output register is full and not taken.
    a_stall_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_out_valid && !i_out_ready) |=> (r_in_valid && $stable(r_in)))
        else $error("input word lost during output stall");

endmodule

`default_nettype wire

// ===== sim/tb_i2c_master_register_transaction.sv =====
`timescale 1ns / 1ps

import i2c_reg_pkg::*;

// Tracks the sequencer state that the block should hold and the results that it owes.
class txn_result_tracker;

    logic [6:0] slave_addr;
    logic [1:0] status_q;
    logic [2:0] pos_q;
    logic       dir_q;
    logic [7:0] reg_addr_q;
    logic [7:0] data_q;
    logic [7:0] left_q;

    t_out_word  expected_outcomes[$];
    int         mismatch_count;
    int         words_checked;

    function new();
        slave_addr     = '0;
        status_q       = ST_AVAIL;
        pos_q          = POS_IDLE;
        dir_q          = DIR_READ;
        reg_addr_q     = '0;
        data_q         = '0;
        left_q         = '0;
        mismatch_count = 0;
        words_checked  = 0;
    endfunction

    function int pending();
        return expected_outcomes.size();
    endfunction

    // Stop, completion notice and a return to available.
    function void close_transaction(inout t_out_word r);
        r.stop     = 1'b1;
        r.done_res = 1'b1;
        status_q   = ST_AVAIL;
        pos_q      = POS_IDLE;
    endfunction

    function t_out_word sequence_step(t_in_word w);
        t_out_word  r;
        logic [7:0] write_addr_byte;
        logic [7:0] read_addr_byte;
        r               = '0;
        write_addr_byte = {slave_addr, 1'b0};
        read_addr_byte  = {slave_addr, 1'b1};
        if (w.cmd == CMD_START) begin
            if (status_q != ST_BUSY && !w.bus_busy) begin
                status_q   = ST_BUSY;
                dir_q      = w.direction;
                reg_addr_q = w.reg_addr;
                data_q     = w.write_data;
                left_q     = (w.read_count == 8'd0) ? 8'd1 : w.read_count;
                if (w.arb_lost) begin
                    r.stop   = 1'b1;
                    status_q = ST_ERR;
                    pos_q    = POS_IDLE;
                end else begin
                    r.accepted   = 1'b1;
                    r.send_start = 1'b1;
                    r.tx_valid   = 1'b1;
                    r.tx_byte    = write_addr_byte;
                    pos_q        = POS_REG;
                end
            end
        end else if (status_q == ST_BUSY) begin
            if (w.arb_lost) begin
                r.stop   = 1'b1;
                status_q = ST_ERR;
                pos_q    = POS_IDLE;
            end else if (pos_q <= POS_REG) begin
                r.tx_valid = 1'b1;
                r.tx_byte  = reg_addr_q;
                pos_q      = POS_SEC;
            end else if (dir_q == DIR_WRITE) begin
                if (pos_q == POS_SEC) begin
                    r.tx_valid = 1'b1;
                    r.tx_byte  = data_q;
                    pos_q      = POS_RXM;
                end else begin
                    close_transaction(r);
                end
            end else begin
                case (pos_q)
                    POS_SEC: begin
                        r.repeated_start = 1'b1;
                        r.tx_valid       = 1'b1;
                        r.tx_byte        = read_addr_byte;
                        pos_q            = POS_RXM;
                    end
                    POS_RXM: begin
                        r.rx_mode  = 1'b1;
                        r.send_nak = (left_q <= 8'd1);
                        pos_q      = POS_DATA;
                    end
                    POS_DATA: begin
                        r.rx_valid = 1'b1;
                        r.rx_data  = w.rx_byte;
                        if (left_q != 8'd0) left_q = left_q - 8'd1;
                        if (left_q == 8'd0) begin
                            close_transaction(r);
                        end else if (left_q == 8'd1) begin
                            r.send_nak = 1'b1;
                        end
                    end
                    default: begin
                        close_transaction(r);
                    end
                endcase
            end
        end
        r.status = status_q;
        return r;
    endfunction

    function void note_word(t_in_word w);
        expected_outcomes.push_back(sequence_step(w));
    endfunction

    function void compare_field(string field, logic [7:0] want, logic [7:0] got);
        if (want !== got) begin
            $display("%0t: %s differs, expected %0h, actual %0h", $time, field, want, got);
            mismatch_count++;
        end
    endfunction

    function void check_word(t_out_word got);
        t_out_word want;
        if (expected_outcomes.size() == 0) begin
            $display("%0t: result word with none expected, expected nothing, actual %h",
                     $time, got);
            mismatch_count++;
            return;
        end
        want = expected_outcomes.pop_front();
        words_checked++;
        compare_field("accepted", want.accepted, got.accepted);
        compare_field("tx_valid", want.tx_valid, got.tx_valid);
        compare_field("tx_byte", want.tx_byte, got.tx_byte);
        compare_field("send_start", want.send_start, got.send_start);
        compare_field("repeated_start", want.repeated_start, got.repeated_start);
        compare_field("rx_mode", want.rx_mode, got.rx_mode);
        compare_field("send_nak", want.send_nak, got.send_nak);
        compare_field("rx_valid", want.rx_valid, got.rx_valid);
        compare_field("rx_data", want.rx_data, got.rx_data);
        compare_field("stop", want.stop, got.stop);
        compare_field("done_res", want.done_res, got.done_res);
        compare_field("status", want.status, got.status);
    endfunction

endclass

module tb_i2c_master_register_transaction;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_ready;
    t_in_word   i_in_word;
    logic       o_out_valid;
    logic       i_out_ready;
    t_out_word  o_out_word;
    logic       i_cfg_wr_en;
    logic [6:0] i_cfg_wr_data;

    txn_result_tracker book;

    // Idling controls shared between the main sequence and the receiving side.
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_left     = 0;

    int directed_words = 0;
    int random_words   = 0;
    int phase_items    = 0;
    int transactions   = 0;
    int cfg_writes     = 0;

    i2c_master_register_transaction u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_in_word     (i_in_word),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_out_word    (o_out_word),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data)
    );

    // A 10 ns clock. Everything the testbench drives changes on the falling edge, so
    // the block always sees settled inputs at the rising edge where it samples them.
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Receiving side. It idles at the chosen rate, and when the main sequence asks for
    // a hold-off it keeps ready low while that hold-off, counted down here, lasts, so that the
    // output register and then the input register fill up and the input stalls.
    initial begin
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!i_rst_n) begin
                i_out_ready <= 1'b0;
            end else if (hold_left > 0) begin
                i_out_ready <= 1'b0;
                hold_left--;
            end else begin
                i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Every result word accepted at a rising edge is checked against the oldest one
    // that the predictor has queued.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            book.check_word(o_out_word);
        end
    end

    // Offers one word, possibly after some idle cycles, and holds it until the block
    // takes it. Valid is left high afterwards, so a following word can go straight on
    // at the next falling edge without valid dropping in between.
    task automatic send_word(input t_in_word w);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        book.note_word(w);
    endtask

    task automatic release_sender();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
    endtask

    // Waits until every predicted result has been seen, then lets the pipeline
    // settle with some margin.
    task automatic wait_drained();
        while (book.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Only ever called with the block idle, so the new address applies from the next
    // transaction onwards in both the block and the predictor.
    task automatic write_slave_address(input logic [6:0] addr);
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= addr;
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        book.slave_addr = addr;
        cfg_writes++;
    endtask

    function automatic t_in_word make_start(input logic dir, input logic [7:0] reg_addr,
                                            input logic [7:0] wdata, input logic [7:0] count,
                                            input logic busy, input logic arb);
        t_in_word w;
        w            = '0;
        w.cmd        = CMD_START;
        w.direction  = dir;
        w.reg_addr   = reg_addr;
        w.write_data = wdata;
        w.read_count = count;
        w.bus_busy   = busy;
        w.arb_lost   = arb;
        return w;
    endfunction

    function automatic t_in_word make_event(input logic arb, input logic [7:0] rxb);
        t_in_word w;
        w          = '0;
        w.cmd      = CMD_EVENT;
        w.arb_lost = arb;
        w.rx_byte  = rxb;
        return w;
    endfunction

    // Every bit of the word random; callers then pin down the fields that matter.
    function automatic t_in_word random_word();
        logic [63:0] raw;
        raw = {$urandom(), $urandom()};
        return t_in_word'(raw[$bits(t_in_word)-1:0]);
    endfunction

    // One well-formed transaction with random content: a start followed by exactly the
    // events that its direction and read count call for. Now and then the start is
    // refused or loses arbitration, the sequence is cut short, or a stray word follows,
    // so that refusals, ignored events and restarts after an error keep turning up.
    task automatic drive_transaction();
        t_in_word w;
        int       steps;
        int       i;
        w            = random_word();
        w.cmd        = CMD_START;
        w.bus_busy   = ($urandom_range(99) < 6);
        w.arb_lost   = ($urandom_range(99) < 3);
        w.read_count = ($urandom_range(99) < 2) ? 8'($urandom_range(255))
                                                : 8'($urandom_range(4));
        if (w.direction == DIR_WRITE) begin
            steps = 3;
        end else begin
            steps = 3 + ((w.read_count == 8'd0) ? 1 : int'(w.read_count));
        end
        if ($urandom_range(99) < 5) steps = $urandom_range(steps);
        send_word(w);
        transactions++;
        phase_items++;
        for (i = 0; i < steps; i++) begin
            w          = random_word();
            w.cmd      = CMD_EVENT;
            w.arb_lost = ($urandom_range(199) == 0);
            send_word(w);
            phase_items++;
        end
        random_words += steps + 1;
        if ($urandom_range(99) < 8) begin
            send_word(random_word());
            random_words++;
        end
    endtask

    initial begin
        int         phase;
        bit         held;
        bit         paused;
        logic [6:0] addr_sel;

        book          = new();
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_in_word     = '0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_wr_data = '0;

        // Reset is applied at the start, once only.
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part, run with the top slave address so the address bytes carry
        // all ones above the read/write bit.
        write_slave_address(7'h7F);

        // An event while idle is ignored, and a start with the bus busy is refused.
        send_word(make_event(1'b0, 8'hA5));
        send_word(make_start(DIR_WRITE, 8'h12, 8'h34, 8'h00, 1'b1, 1'b0));

        // A full register write with extreme register and data bytes.
        send_word(make_start(DIR_WRITE, 8'hFF, 8'h00, 8'h00, 1'b0, 1'b0));
        repeat (3) send_word(make_event(1'b0, 8'h00));

        // A read with a count of zero behaves as a single-byte read, NAK straight away.
        send_word(make_start(DIR_READ, 8'h00, 8'hFF, 8'h00, 1'b0, 1'b0));
        repeat (3) send_word(make_event(1'b0, 8'h5A));
        send_word(make_event(1'b0, 8'hFF));

        // A two-byte read: ACK on the first data byte, NAK raised for the last.
        send_word(make_start(DIR_READ, 8'h80, 8'h01, 8'h02, 1'b0, 1'b0));
        repeat (3) send_word(make_event(1'b0, 8'h3C));
        send_word(make_event(1'b0, 8'hFF));
        send_word(make_event(1'b0, 8'h00));

        // The longest read is started, a second start is refused while it runs, and
        // an arbitration loss then aborts it into the error state.
        send_word(make_start(DIR_READ, 8'h01, 8'h80, 8'hFF, 1'b0, 1'b0));
        send_word(make_start(DIR_WRITE, 8'h22, 8'h33, 8'h00, 1'b0, 1'b0));
        send_word(make_event(1'b1, 8'h00));

        // From the error state a start is allowed again: first one that loses
        // arbitration at once, then a clean write that runs to completion.
        send_word(make_start(DIR_WRITE, 8'h55, 8'hAA, 8'h01, 1'b0, 1'b1));
        send_word(make_start(DIR_WRITE, 8'hAA, 8'h55, 8'h01, 1'b0, 1'b0));
        repeat (3) send_word(make_event(1'b0, 8'hFF));
        directed_words = 25;

        release_sender();
        wait_drained();

        // Random part in three phases, each with its own slave address and idling
        // pattern: a slow receiver first, then a slow sender, then no idling at all.
        for (phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    addr_sel      = 7'h00;
                    send_idle_pct = 32;
                    recv_idle_pct = 68;
                end
                1: begin
                    addr_sel      = 7'($urandom_range(127));
                    send_idle_pct = 68;
                    recv_idle_pct = 32;
                end
                default: begin
                    addr_sel      = 7'h55;
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            write_slave_address(addr_sel);
            phase_items = 0;
            held        = 1'b0;
            paused      = 1'b0;
            while (phase_items < 500) begin
                drive_transaction();
                // With no idling the receiver stops for a long stretch while words keep
                // coming, which backs the block up until its input stalls.
                if (phase == 2 && !held && phase_items >= 150) begin
                    hold_left = 64;
                    held      = 1'b1;
                end
                // Later the sender stops altogether until every result is back.
                if (phase == 2 && !paused && phase_items >= 350) begin
                    release_sender();
                    wait_drained();
                    paused = 1'b1;
                end
            end
            release_sender();
            wait_drained();
        end

        if (book.pending() != 0) begin
            $display("%0t: %0d expected result words never arrived", $time, book.pending());
            book.mismatch_count++;
        end

        $display("Covered %0d directed and %0d random words in %0d random transactions.",
                 directed_words, random_words, transactions);
        $display("Checked %0d result words over %0d slave address settings.",
                 book.words_checked, cfg_writes);
        if (book.mismatch_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // Guard against a hung handshake; far beyond the slowest legal run.
    initial begin
        #4ms;
        $display("FAILURE");
        $finish;
    end

endmodule
